@@ design/hsrr_pkg.sv @@
// Shared types and constants for the haze scene radiance recovery core.
package hsrr_pkg;

  localparam int TRANS_FRAC_BITS = 12;
  localparam int TRANS_W         = TRANS_FRAC_BITS + 1;
  localparam int PIX_W           = 8;
  localparam int NUM_CH          = 3;
  localparam int DIV_W           = PIX_W + TRANS_FRAC_BITS;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = TRANS_W;

  localparam logic [PIX_W-1:0]   LIGHT_RESET = PIX_W'(225);
  localparam logic [PIX_W-1:0]   CEIL_RESET  = PIX_W'(225);
  localparam logic [TRANS_W-1:0] FLOOR_RESET = TRANS_W'(410);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIGHT_BLUE  = 3'd0,
    CFG_LIGHT_GREEN = 3'd1,
    CFG_LIGHT_RED   = 3'd2,
    CFG_CEILING     = 3'd3,
    CFG_TRANS_FLOOR = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel_blue;
    logic [PIX_W-1:0]   pixel_green;
    logic [PIX_W-1:0]   pixel_red;
    logic [TRANS_W-1:0] transmission_level;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] clear_blue;
    logic [PIX_W-1:0] clear_green;
    logic [PIX_W-1:0] clear_red;
  } out_t;

  typedef struct packed {
    logic [NUM_CH-1:0]            neg;
    logic [NUM_CH-1:0][PIX_W-1:0] raw;
  } side_t;

endpackage

@@ design/hsrr_div_pipe.sv @@
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage.
module hsrr_div_pipe import hsrr_pkg::*; (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic [TRANS_W-1:0]               in_divisor,
  input  logic [NUM_CH-1:0][DIV_W-1:0]     in_dividend,
  input  side_t                            in_side,
  output logic                             out_valid,
  output logic [NUM_CH-1:0][DIV_W-1:0]     out_quot,
  output logic [NUM_CH-1:0]                out_rem_nz,
  output side_t                            out_side
);

  logic                             vld_r  [DIV_W];
  logic [TRANS_W-1:0]               dvs_r  [DIV_W];
  logic [NUM_CH-1:0][TRANS_W-1:0]   rem_r  [DIV_W];
  logic [NUM_CH-1:0][DIV_W-1:0]     dq_r   [DIV_W];
  side_t                            side_r [DIV_W];

  for (genvar s = 0; s < DIV_W; s++) begin : g_stage
    logic                           vld_in;
    logic [TRANS_W-1:0]             dvs_in;
    logic [NUM_CH-1:0][TRANS_W-1:0] rem_in;
    logic [NUM_CH-1:0][DIV_W-1:0]   dq_in;
    side_t                          side_in;
    logic [NUM_CH-1:0][TRANS_W:0]   trial;
    logic [NUM_CH-1:0][TRANS_W:0]   sub;
    logic [NUM_CH-1:0]              ge;
    logic [NUM_CH-1:0][TRANS_W-1:0] rem_nxt;
    logic [NUM_CH-1:0][DIV_W-1:0]   dq_nxt;

    if (s == 0) begin : g_first
      assign vld_in  = in_valid;
      assign dvs_in  = in_divisor;
      assign rem_in  = '0;
      assign dq_in   = in_dividend;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[s-1];
      assign dvs_in  = dvs_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign dq_in   = dq_r[s-1];
      assign side_in = side_r[s-1];
    end

    always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
        trial[c]   = {rem_in[c], dq_in[c][DIV_W-1]};
        sub[c]     = trial[c] - {1'b0, dvs_in};
        ge[c]      = (trial[c] >= {1'b0, dvs_in});
        rem_nxt[c] = ge[c] ? sub[c][TRANS_W-1:0] : trial[c][TRANS_W-1:0];
        dq_nxt[c]  = {dq_in[c][DIV_W-2:0], ge[c]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      dvs_r[s]  <= dvs_in;
      rem_r[s]  <= rem_nxt;
      dq_r[s]   <= dq_nxt;
      side_r[s] <= side_in;
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      out_rem_nz[c] = |rem_r[DIV_W-1][c];
    end
  end

  assign out_valid = vld_r[DIV_W-1];
  assign out_quot  = dq_r[DIV_W-1];
  assign out_side  = side_r[DIV_W-1];

endmodule

@@ design/haze_scene_radiance_recovery_core.sv @@
// Top level of the haze scene radiance recovery core: config, pre/post stages, divider.
//
// One pixel enters per clock while busy is low. On its way to the result ports the item
// passes 23 registers: one input stage, 20 divider stages at one quotient bit each, one
// sign stage and one output register. The divider stages make up most of them. The result
// is on out_data for one cycle while out_valid is high and cannot be held off. busy is
// high only during reset and the first cycle after it; cfg_ready is always high.
module haze_scene_radiance_recovery_core import hsrr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  in_t                   in_data,
  output logic                  busy,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  output out_t                  out_data
);

  localparam int V_W = DIV_W + 2;
  localparam int LAT = DIV_W + 3;

  logic [NUM_CH-1:0][PIX_W-1:0] light_r;
  logic [PIX_W-1:0]             ceil_r;
  logic [TRANS_W-1:0]           floor_r;
  logic                         busy_r;

  assign cfg_ready = 1'b1;
  assign busy      = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_r <= {NUM_CH{LIGHT_RESET}};
      ceil_r  <= CEIL_RESET;
      floor_r <= FLOOR_RESET;
      busy_r  <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_LIGHT_BLUE:  light_r[0] <= cfg_data[PIX_W-1:0];
          CFG_LIGHT_GREEN: light_r[1] <= cfg_data[PIX_W-1:0];
          CFG_LIGHT_RED:   light_r[2] <= cfg_data[PIX_W-1:0];
          CFG_CEILING:     ceil_r     <= cfg_data[PIX_W-1:0];
          CFG_TRANS_FLOOR: floor_r    <= cfg_data[TRANS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // input stage
  logic                         in_acc;
  logic [TRANS_W-1:0]           floor_eff;
  logic [TRANS_W-1:0]           t_eff;
  logic [NUM_CH-1:0][PIX_W-1:0] raw;
  logic [NUM_CH-1:0][PIX_W-1:0] mag;
  side_t                        side_nxt;
  logic [NUM_CH-1:0][DIV_W-1:0] dvd_nxt;

  logic                         s0_vld_r;
  logic [TRANS_W-1:0]           s0_t_r;
  logic [NUM_CH-1:0][DIV_W-1:0] s0_dvd_r;
  side_t                        s0_side_r;

  assign in_acc = start && !busy_r;

  always_comb begin
    floor_eff = (floor_r == '0) ? TRANS_W'(1) : floor_r;
    t_eff     = (in_data.transmission_level < floor_eff) ? floor_eff
                                                         : in_data.transmission_level;
    raw[0] = in_data.pixel_blue;
    raw[1] = in_data.pixel_green;
    raw[2] = in_data.pixel_red;
    for (int c = 0; c < NUM_CH; c++) begin
      side_nxt.neg[c] = (raw[c] < light_r[c]);
      side_nxt.raw[c] = raw[c];
      mag[c]          = side_nxt.neg[c] ? (light_r[c] - raw[c]) : (raw[c] - light_r[c]);
      dvd_nxt[c]      = {mag[c], {TRANS_FRAC_BITS{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    s0_t_r    <= t_eff;
    s0_dvd_r  <= dvd_nxt;
    s0_side_r <= side_nxt;
  end

  // divider
  logic                         dv_vld;
  logic [NUM_CH-1:0][DIV_W-1:0] dv_quot;
  logic [NUM_CH-1:0]            dv_nz;
  side_t                        dv_side;

  hsrr_div_pipe u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (s0_vld_r),
    .in_divisor  (s0_t_r),
    .in_dividend (s0_dvd_r),
    .in_side     (s0_side_r),
    .out_valid   (dv_vld),
    .out_quot    (dv_quot),
    .out_rem_nz  (dv_nz),
    .out_side    (dv_side)
  );

  // sign stage: floor toward minus infinity
  logic [NUM_CH-1:0][DIV_W:0]   qmag;
  logic [NUM_CH-1:0][DIV_W:0]   q_nxt;
  logic                         p_vld_r;
  logic [NUM_CH-1:0][DIV_W:0]   p_q_r;
  logic [NUM_CH-1:0][PIX_W-1:0] p_raw_r;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      qmag[c]  = {1'b0, dv_quot[c]} + {{DIV_W{1'b0}}, dv_nz[c]};
      q_nxt[c] = dv_side.neg[c] ? (~qmag[c] + (DIV_W+1)'(1)) : {1'b0, dv_quot[c]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    p_q_r   <= q_nxt;
    p_raw_r <= dv_side.raw;
  end

  // output stage: add light, pass the raw pixel above the ceiling, clamp at zero
  logic [NUM_CH-1:0][V_W-1:0]   v;
  logic [NUM_CH-1:0][PIX_W-1:0] res;
  logic [V_W-1:0]               ceil_ext;
  logic                         out_vld_r;
  out_t                         out_data_r;

  always_comb begin
    ceil_ext = {{(V_W-PIX_W){1'b0}}, ceil_r};
    for (int c = 0; c < NUM_CH; c++) begin
      v[c] = {{(V_W-PIX_W){1'b0}}, light_r[c]} + {p_q_r[c][DIV_W], p_q_r[c]};
      priority if (!v[c][V_W-1] && (v[c] > ceil_ext)) begin
        res[c] = p_raw_r[c];
      end else if (v[c][V_W-1]) begin
        res[c] = '0;
      end else begin
        res[c] = v[c][PIX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= p_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r.clear_blue  <= res[0];
    out_data_r.clear_green <= res[1];
    out_data_r.clear_red   <= res[2];
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##LAT out_valid)
    else $error("transfer did not produce a result at the pipeline latency");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_acc, LAT))
    else $error("result without a matching input transfer");

  a_busy_reset: assert property (@(posedge clk)
    !rst_n |=> busy)
    else $error("busy low right after reset");

endmodule
